// ----- hw/rtl/ifp_pkg.sv -----
// ----------------------------------------------------------------------------
// ifp_pkg
// Shared widths, fixed-point constants and types of the fern point generator.
// ----------------------------------------------------------------------------
package ifp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int RAND_BITS = 15;
  localparam int COORD_W   = FRAC_BITS + 8;
  localparam int COEF_W    = FRAC_BITS + 2;
  localparam int ITER_W    = 8;
  localparam int PHASE_W   = 9;
  localparam int OUT_W     = 20;

  localparam logic [ITER_W-1:0] ITER_RESET = ITER_W'(20);

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // window of emitted points
  localparam logic signed [COORD_W-1:0] X_HI = COORD_W'(longint'(5) <<< FRAC_BITS);
  localparam logic signed [COORD_W-1:0] X_LO = -X_HI;
  localparam logic signed [COORD_W-1:0] Y_HI = COORD_W'(longint'(10) <<< FRAC_BITS);

  // start coordinate: round(word * 2^FRAC_BITS / 50000) by reciprocal multiply
  localparam int START_DIV     = 50000;
  localparam int START_BIAS    = START_DIV / 2;
  localparam int START_NUM_W   = RAND_BITS + ((FRAC_BITS > 15) ? FRAC_BITS : 15);
  localparam int START_SHIFT   = START_NUM_W + 16;
  localparam int START_RECIP_W = START_SHIFT - 15;
  localparam int START_Q_W     = START_NUM_W + START_RECIP_W - START_SHIFT;
  localparam longint START_RECIP_L =
    ((longint'(1) <<< START_SHIFT) + longint'(START_DIV) - 1) / longint'(START_DIV);
  localparam logic [START_RECIP_W-1:0] START_RECIP = START_RECIP_W'(START_RECIP_L);

  // map choice thresholds on 100 * word
  localparam int R100_W = RAND_BITS + 7;
  localparam logic [R100_W-1:0] RAND_TOP = R100_W'((longint'(1) <<< RAND_BITS) - 1);
  localparam logic [R100_W-1:0] TH_STEM  = RAND_TOP;
  localparam logic [R100_W-1:0] TH_LEAF  = R100_W'(86 * ((longint'(1) <<< RAND_BITS) - 1));
  localparam logic [R100_W-1:0] TH_LEFT  = R100_W'(93 * ((longint'(1) <<< RAND_BITS) - 1));

  function automatic logic signed [COEF_W-1:0] coef(input int h);
    return COEF_W'(((longint'(h) <<< FRAC_BITS) + 64'sd50) / 64'sd100);
  endfunction

  localparam logic signed [COEF_W-1:0] C_ZERO = '0;
  localparam logic signed [COEF_W-1:0] C_P16  = coef(16);
  localparam logic signed [COEF_W-1:0] C_P85  = coef(85);
  localparam logic signed [COEF_W-1:0] C_P04  = coef(4);
  localparam logic signed [COEF_W-1:0] C_N04  = -coef(4);
  localparam logic signed [COEF_W-1:0] C_P20  = coef(20);
  localparam logic signed [COEF_W-1:0] C_N26  = -coef(26);
  localparam logic signed [COEF_W-1:0] C_P23  = coef(23);
  localparam logic signed [COEF_W-1:0] C_P22  = coef(22);
  localparam logic signed [COEF_W-1:0] C_N15  = -coef(15);
  localparam logic signed [COEF_W-1:0] C_P28  = coef(28);
  localparam logic signed [COEF_W-1:0] C_P26  = coef(26);
  localparam logic signed [COEF_W-1:0] C_P24  = coef(24);

  localparam logic signed [COORD_W-1:0] K_ZERO = '0;
  localparam logic signed [COORD_W-1:0] K_160  =
    COORD_W'(((longint'(160) <<< FRAC_BITS) + 64'sd50) / 64'sd100);
  localparam logic signed [COORD_W-1:0] K_044  =
    COORD_W'(((longint'(44) <<< FRAC_BITS) + 64'sd50) / 64'sd100);

  typedef struct packed {
    logic signed [COEF_W-1:0]  xa;
    logic signed [COEF_W-1:0]  xb;
    logic signed [COEF_W-1:0]  ya;
    logic signed [COEF_W-1:0]  yb;
    logic signed [COORD_W-1:0] yk;
  } map_coef_t;

endpackage

// ----- hw/rtl/ifp_start_coord.sv -----
// ----------------------------------------------------------------------------
// ifp_start_coord
// Start coordinate from a random word: rounded word * 2^FRAC_BITS / 50000.
// ----------------------------------------------------------------------------
module ifp_start_coord (
  input  logic [ifp_pkg::RAND_BITS-1:0]      word,
  output logic signed [ifp_pkg::COORD_W-1:0] coord
);
  import ifp_pkg::*;

  localparam int PROD_W = START_NUM_W + START_RECIP_W;
  localparam int CMP_W  = START_Q_W + COORD_W;

  logic [START_NUM_W-1:0] num;
  logic [PROD_W-1:0]      prod;
  logic [START_Q_W-1:0]   quo;
  logic                   over;

  assign num  = (START_NUM_W'(word) << FRAC_BITS) + START_NUM_W'(START_BIAS);
  assign prod = PROD_W'(num) * PROD_W'(START_RECIP);
  assign quo  = prod[START_SHIFT +: START_Q_W];
  assign over = CMP_W'(quo) > CMP_W'(COORD_MAX);

  assign coord = over ? COORD_MAX : COORD_W'(quo);

endmodule

// ----- hw/rtl/ifp_map_select.sv -----
// ----------------------------------------------------------------------------
// ifp_map_select
// Picks one of the four fern maps from a random word and gives its coefficients.
// ----------------------------------------------------------------------------
module ifp_map_select (
  input  logic [ifp_pkg::RAND_BITS-1:0] word,
  output ifp_pkg::map_coef_t            coef_o
);
  import ifp_pkg::*;

  logic [R100_W-1:0] r100;

  assign r100 = R100_W'(word) * R100_W'(100);

  always_comb begin
    priority if (r100 < TH_STEM) begin
      coef_o = '{xa: C_ZERO, xb: C_ZERO, ya: C_ZERO, yb: C_P16, yk: K_ZERO};
    end else if (r100 < TH_LEAF) begin
      coef_o = '{xa: C_P85, xb: C_P04, ya: C_N04, yb: C_P85, yk: K_160};
    end else if (r100 < TH_LEFT) begin
      coef_o = '{xa: C_P20, xb: C_N26, ya: C_P23, yb: C_P22, yk: K_160};
    end else begin
      coef_o = '{xa: C_N15, xb: C_P28, ya: C_P26, yb: C_P24, yk: K_044};
    end
  end

endmodule

// ----- hw/rtl/ifp_map_term.sv -----
// ----------------------------------------------------------------------------
// ifp_map_term
// One affine term: round(c1*a + c2*b) + k, rounded half up, saturated.
// ----------------------------------------------------------------------------
module ifp_map_term (
  input  logic signed [ifp_pkg::COEF_W-1:0]  c1,
  input  logic signed [ifp_pkg::COORD_W-1:0] a,
  input  logic signed [ifp_pkg::COEF_W-1:0]  c2,
  input  logic signed [ifp_pkg::COORD_W-1:0] b,
  input  logic signed [ifp_pkg::COORD_W-1:0] k,
  output logic signed [ifp_pkg::COORD_W-1:0] res
);
  import ifp_pkg::*;

  localparam int PROD_W = COEF_W + COORD_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int SHR_W  = SUM_W - FRAC_BITS;
  localparam int ACC_W  = SHR_W + 1;

  localparam logic signed [SUM_W-1:0] HALF =
    {{(SUM_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

  logic signed [PROD_W-1:0] p1;
  logic signed [PROD_W-1:0] p2;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  shr;
  logic signed [SHR_W-1:0]  rnd;
  logic signed [ACC_W-1:0]  acc;

  assign p1  = PROD_W'(c1) * PROD_W'(a);
  assign p2  = PROD_W'(c2) * PROD_W'(b);
  assign sum = SUM_W'(p1) + SUM_W'(p2) + HALF;
  assign shr = sum >>> FRAC_BITS;
  assign rnd = shr[SHR_W-1:0];
  assign acc = ACC_W'(rnd) + ACC_W'(k);

  always_comb begin
    priority if (acc > ACC_W'(COORD_MAX)) begin
      res = COORD_MAX;
    end else if (acc < ACC_W'(COORD_MIN)) begin
      res = COORD_MIN;
    end else begin
      res = acc[COORD_W-1:0];
    end
  end

endmodule

// ----- hw/rtl/ifs_fern_point_generator.sv -----
// ----------------------------------------------------------------------------
// ifs_fern_point_generator
// Chaos-game point generator for the fern iterated function system.
// ----------------------------------------------------------------------------
// Each point takes iterations + 2 input beats: start x, start y, then one map
// choice per beat (an iterations value of zero counts as one). The block takes
// one beat every clock unless in_stall is high; a beat waits in the input
// register and is applied from there, the four 24x18 products of the map
// datapath setting the clock. A point inside x in [-5,5], y in [0,10] enters
// the result register with its last beat; others are dropped. Coordinates are
// signed Q8.16. Write iterations only while the block is idle.
// ----------------------------------------------------------------------------
module ifs_fern_point_generator (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [ifp_pkg::ITER_W-1:0]         cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [ifp_pkg::RAND_BITS-1:0]      in_random_word,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [ifp_pkg::OUT_W-1:0]   out_point_x,
  output logic [ifp_pkg::OUT_W-1:0]          out_point_y
);
  import ifp_pkg::*;

  logic [ITER_W-1:0]          iter_r;
  logic                       in_valid_r;
  logic [RAND_BITS-1:0]       word_r;
  logic [PHASE_W-1:0]         phase_r;
  logic signed [COORD_W-1:0]  cur_x_r;
  logic signed [COORD_W-1:0]  cur_y_r;
  logic                       out_valid_r;
  logic signed [OUT_W-1:0]    out_x_r;
  logic [OUT_W-1:0]           out_y_r;

  logic                       advance;
  logic                       fire;
  logic [ITER_W-1:0]          need;
  logic [PHASE_W-1:0]         done;
  logic                       more;
  logic                       in_window;
  logic                       emit;
  logic signed [COORD_W-1:0]  start_val;
  map_coef_t                  coef;
  logic signed [COORD_W-1:0]  nx;
  logic signed [COORD_W-1:0]  ny;

  ifp_start_coord u_start (
    .word  (word_r),
    .coord (start_val)
  );

  ifp_map_select u_sel (
    .word   (word_r),
    .coef_o (coef)
  );

  ifp_map_term u_term_x (
    .c1  (coef.xa),
    .a   (cur_x_r),
    .c2  (coef.xb),
    .b   (cur_y_r),
    .k   (K_ZERO),
    .res (nx)
  );

  ifp_map_term u_term_y (
    .c1  (coef.ya),
    .a   (cur_x_r),
    .c2  (coef.yb),
    .b   (cur_y_r),
    .k   (coef.yk),
    .res (ny)
  );

  assign advance   = ~out_valid_r | ~out_stall;
  assign fire      = in_valid_r & advance;
  assign in_stall  = in_valid_r & ~advance;

  assign need      = (iter_r == '0) ? ITER_W'(1) : iter_r;
  assign done      = phase_r - PHASE_W'(1);
  assign more      = done < PHASE_W'(need);
  assign in_window = (nx >= X_LO) && (nx <= X_HI) && (ny >= K_ZERO) && (ny <= Y_HI);
  assign emit      = (phase_r >= PHASE_W'(2)) && !more && in_window;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_r <= ITER_RESET;
    end else if (cfg_wr_en) begin
      iter_r <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      word_r <= in_random_word;
    end
  end

  // point state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      cur_x_r <= '0;
      cur_y_r <= '0;
    end else if (fire) begin
      priority if (phase_r == PHASE_W'(0)) begin
        cur_x_r <= start_val;
        phase_r <= PHASE_W'(1);
      end else if (phase_r == PHASE_W'(1)) begin
        cur_y_r <= start_val;
        phase_r <= PHASE_W'(2);
      end else begin
        cur_x_r <= nx;
        cur_y_r <= ny;
        phase_r <= more ? phase_r + PHASE_W'(1) : '0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= fire & emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_x_r <= nx[OUT_W-1:0];
      out_y_r <= ny[OUT_W-1:0];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_point_x = out_x_r;
  assign out_point_y = out_y_r;

endmodule
